FILE: rtl/tlnu_pkg.sv
// Package for the tab-expanding line normalizer.
// Holds character codes, register indexes, field widths and reset values.
// No dependencies.
package tlnu_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TAB_SIZE_W    = 5;
  localparam int unsigned CFG_INDEX_W   = 4;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned MAX_TAB_DEF     = 16;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  localparam logic [TAB_SIZE_W-1:0] TAB_SIZE_RST = 5'd4;
  localparam logic [BYTE_W-1:0]     CELL_ATTR_RST = 8'd36;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAB_SIZE  = 4'd0,
    REG_CELL_ATTR = 4'd1
  } cfg_reg_t;

endpackage

FILE: rtl/tlnu_if.sv
// Channel interfaces of the tab-expanding line normalizer: byte input,
// cell output and configuration write channel.
// Depends on tlnu_pkg.
interface tlnu_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlnu_pkg::BYTE_W-1:0]  data_byte;
  logic                         end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tlnu_out_if;
  logic                         valid;
  logic                         ready;
  logic [tlnu_pkg::BYTE_W-1:0]  char_code;
  logic [tlnu_pkg::BYTE_W-1:0]  attribute;
  logic                         is_cell;
  logic                         line_end;
  logic                         last_of_run;

  modport source (output valid, output char_code, output attribute, output is_cell,
                  output line_end, output last_of_run, input ready);
  modport sink   (input valid, input char_code, input attribute, input is_cell,
                  input line_end, input last_of_run, output ready);
endinterface

interface tlnu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tlnu_pkg::CFG_INDEX_W-1:0]  index;
  logic [tlnu_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tlnu_rem.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one dividend
// bit per cycle. Used for the column position inside a tab stop.
// Depends on nothing outside this file.
module tlnu_rem #(
  parameter int unsigned DVD_BITS = 16,
  parameter int unsigned DVS_BITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVS_BITS-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DVD_BITS + 1);

  logic [DVS_BITS:0]   rem_r, rem_nxt;
  logic [DVD_BITS-1:0] dvd_r, dvd_nxt;
  logic [DVS_BITS-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DVS_BITS:0]   shifted;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DVS_BITS-1:0], dvd_r[DVD_BITS-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract when the partial remainder covers the divisor
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
      end else begin
        rem_nxt = shifted;
      end
      dvd_nxt = {dvd_r[DVD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[DVS_BITS-1:0];

endmodule

FILE: rtl/tab_expanding_line_normalizer_unit.sv
// Tab-expanding line normalizer, top level. Depends on tlnu_pkg, tlnu_if, tlnu_rem.
// Results: a plain byte, CR, LF or end of file is registered and shown in the cycle after
// its transfer; a tab's fill spaces follow the serial remainder and the hand-off to S_FILL.
// Throughput: one item per cycle for those while the output is not stalled; a tab holds
// the input through transfer, serial remainder and hand-off, then while its spaces go out.
// Reset (rst_n low, synchronous): column and CR flag clear, output empty, tab 4, attr 36.
module tab_expanding_line_normalizer_unit #(
  parameter int unsigned COLUMN_BITS = tlnu_pkg::COLUMN_BITS_DEF,
  parameter int unsigned MAX_TAB     = tlnu_pkg::MAX_TAB_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tlnu_in_if.sink     in_ch,
  tlnu_out_if.source  out_ch,
  tlnu_cfg_if.sink    cfg_ch
);

  // width of a tab count (1 .. MAX_TAB)
  localparam int unsigned TW  = $clog2(MAX_TAB + 1);
  // common width for comparing the tab register with MAX_TAB
  localparam int unsigned TSW = (TW > tlnu_pkg::TAB_SIZE_W) ? TW : tlnu_pkg::TAB_SIZE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FILL
  } state_t;

  state_t                          state_r, state_nxt;
  logic [COLUMN_BITS-1:0]          column_r, column_nxt;
  logic                            after_cr_r, after_cr_nxt;
  logic [TW-1:0]                   fill_cnt_r, fill_cnt_nxt;
  logic [tlnu_pkg::TAB_SIZE_W-1:0] tab_size_r;
  logic [tlnu_pkg::BYTE_W-1:0]     attr_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [tlnu_pkg::BYTE_W-1:0]     out_char_r, out_char_nxt;
  logic [tlnu_pkg::BYTE_W-1:0]     out_attr_r, out_attr_nxt;
  logic                            out_cell_r, out_cell_nxt;
  logic                            out_lend_r, out_lend_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic                            in_xfer;
  logic                            cfg_xfer;
  logic                            div_start;
  logic                            div_done;
  logic [TW-1:0]                   div_rem;
  logic [TSW-1:0]                  ts_ext;
  logic [TW-1:0]                   tab_eff;
  logic [COLUMN_BITS-1:0]          column_inc;

  // output slot can take a new result this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;

  // clamp tab size: zero acts as one, above MAX_TAB acts as MAX_TAB
  always_comb begin
    ts_ext = TSW'(tab_size_r);
    if (ts_ext == '0) begin
      tab_eff = TW'(1);
    end else if (ts_ext > TSW'(MAX_TAB)) begin
      tab_eff = TW'(MAX_TAB);
    end else begin
      tab_eff = ts_ext[TW-1:0];
    end
  end

  // saturating column advance by one
  assign column_inc = (column_r == '1) ? column_r : column_r + 1'b1;

  assign div_start = in_xfer && !in_ch.end_of_file && (in_ch.data_byte == tlnu_pkg::CH_TAB);

  tlnu_rem #(
    .DVD_BITS (COLUMN_BITS),
    .DVS_BITS (TW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (column_r),
    .divisor   (tab_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    column_nxt    = column_r;
    after_cr_nxt  = after_cr_r;
    fill_cnt_nxt  = fill_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_cell_nxt  = out_cell_r;
    out_lend_nxt  = out_lend_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_attr_nxt = attr_r;
          if (in_ch.end_of_file) begin
            // line-close marker
            out_valid_nxt = 1'b1;
            out_char_nxt  = tlnu_pkg::CH_NUL;
            out_cell_nxt  = 1'b0;
            out_lend_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
            column_nxt    = '0;
            after_cr_nxt  = 1'b0;
          end else if (in_ch.data_byte == tlnu_pkg::CH_CR) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = tlnu_pkg::CH_LF;
            out_cell_nxt  = 1'b1;
            out_lend_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
            column_nxt    = '0;
            after_cr_nxt  = 1'b1;
          end else if (in_ch.data_byte == tlnu_pkg::CH_LF) begin
            // LF right after CR is swallowed
            after_cr_nxt = 1'b0;
            if (!after_cr_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = tlnu_pkg::CH_LF;
              out_cell_nxt  = 1'b1;
              out_lend_nxt  = 1'b1;
              out_last_nxt  = 1'b1;
              column_nxt    = '0;
            end
          end else if (in_ch.data_byte == tlnu_pkg::CH_TAB) begin
            // remainder unit starts on this transfer
            after_cr_nxt = 1'b0;
            state_nxt    = S_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = in_ch.data_byte;
            out_cell_nxt  = 1'b1;
            out_lend_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
            column_nxt    = column_inc;
            after_cr_nxt  = 1'b0;
          end
        end
      end
      S_DIV: begin
        // fill count is the distance to the next tab stop
        if (div_done) begin
          fill_cnt_nxt = tab_eff - div_rem;
          state_nxt    = S_FILL;
        end
      end
      S_FILL: begin
        // one space per cycle while the output slot is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = tlnu_pkg::CH_SPACE;
          out_attr_nxt  = attr_r;
          out_cell_nxt  = 1'b1;
          out_lend_nxt  = 1'b0;
          out_last_nxt  = (fill_cnt_r == TW'(1));
          column_nxt    = column_inc;
          fill_cnt_nxt  = fill_cnt_r - 1'b1;
          if (fill_cnt_r == TW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      column_r    <= '0;
      after_cr_r  <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      tab_size_r  <= tlnu_pkg::TAB_SIZE_RST;
      attr_r      <= tlnu_pkg::CELL_ATTR_RST;
    end else begin
      state_r     <= state_nxt;
      column_r    <= column_nxt;
      after_cr_r  <= after_cr_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // register writes; unknown indexes are dropped
      if (cfg_xfer) begin
        case (cfg_ch.index)
          tlnu_pkg::REG_TAB_SIZE:  tab_size_r <= cfg_ch.data[tlnu_pkg::TAB_SIZE_W-1:0];
          tlnu_pkg::REG_CELL_ATTR: attr_r     <= cfg_ch.data;
          default: ;
        endcase
      end
    end
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_cell_r <= out_cell_nxt;
    out_lend_r <= out_lend_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = out_char_r;
  assign out_ch.attribute   = out_attr_r;
  assign out_ch.is_cell     = out_cell_r;
  assign out_ch.line_end    = out_lend_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for tab_expanding_line_normalizer_unit: byte stream in,
// display cells out, checked against an in-bench model of the normalizer.
// Depends on tlnu_pkg, the tlnu channel interfaces and the RTL top level.
module tb;
  import tlnu_pkg::*;

  localparam int unsigned       COLUMN_BITS  = COLUMN_BITS_DEF;
  localparam int unsigned       MAX_TAB      = MAX_TAB_DEF;
  localparam longint unsigned   COL_MAX      = (64'd1 << COLUMN_BITS) - 64'd1;
  // A CR-LF pair leaves no result behind the LF; give the block this long to settle.
  localparam int unsigned       QUIET_CYCLES = 4;
  localparam int unsigned       END_SETTLE   = COLUMN_BITS + 8;
  localparam int unsigned       DRAIN_LIMIT  = 20000;
  localparam int unsigned       REPORT_MAX   = 10;
  localparam int unsigned       NUM_ROWS     = 22;
  // Bytes that move the column off a tab stop before the stop-size sweep.
  localparam int unsigned       LEAD_BYTES   = 9;

  typedef struct packed {
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] attribute;
    logic              is_cell;
    logic              line_end;
    logic              last_of_run;
  } cell_t;

  // One row of the directed script; typed rows carry their single cell.
  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_file;
    bit                typed;
    cell_t             fixed_cell;
  } script_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst_n;

  tlnu_in_if  in_ch();
  tlnu_out_if out_ch();
  tlnu_cfg_if cfg_ch();

  tab_expanding_line_normalizer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model state: registers as the block should hold them, plus line position.
  logic [TAB_SIZE_W-1:0]  tab_reg;
  logic [BYTE_W-1:0]      attr_reg;
  logic [COLUMN_BITS-1:0] line_col;
  logic                   after_cr;

  cell_t       pending_cells[$];
  script_row_t script_rows [NUM_ROWS];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void push_cell(logic [BYTE_W-1:0] ch, logic is_text, logic lend,
                                    logic last);
    cell_t c;
    c.char_code   = ch;
    c.attribute   = attr_reg;
    c.is_cell     = is_text;
    c.line_end    = lend;
    c.last_of_run = last;
    pending_cells = {pending_cells, c};
  endfunction

  // Advance the column by n, sticking at the top value.
  function automatic void bump_column(int unsigned n);
    longint unsigned sum;
    sum = longint'(line_col) + n;
    if (sum > COL_MAX) begin
      line_col = COL_MAX[COLUMN_BITS-1:0];
    end else begin
      line_col = sum[COLUMN_BITS-1:0];
    end
  endfunction

  // Queue up every cell that one accepted byte should produce.
  function automatic void predict_cells(logic [BYTE_W-1:0] b, logic eof);
    int unsigned stop;
    int unsigned fill;
    if (eof) begin
      // Line-close marker, emitted even if the line is already closed.
      push_cell(CH_NUL, 1'b0, 1'b1, 1'b1);
      line_col = '0;
      after_cr = 1'b0;
    end else if (b == CH_CR) begin
      push_cell(CH_LF, 1'b1, 1'b1, 1'b1);
      line_col = '0;
      after_cr = 1'b1;
    end else if (b == CH_LF) begin
      // Swallow the LF of a CR-LF pair; a lone LF is a newline of its own.
      if (after_cr) begin
        after_cr = 1'b0;
      end else begin
        push_cell(CH_LF, 1'b1, 1'b1, 1'b1);
        line_col = '0;
      end
    end else if (b == CH_TAB) begin
      after_cr = 1'b0;
      // Clamp the stop distance: zero acts as one, anything past MAX_TAB as MAX_TAB.
      stop = tab_reg;
      if (stop == 0) stop = 1;
      if (stop > MAX_TAB) stop = MAX_TAB;
      fill = stop - (line_col % stop);
      for (int unsigned k = 0; k < fill; k++) begin
        push_cell(CH_SPACE, 1'b1, 1'b0, k + 1 == fill);
      end
      bump_column(fill);
    end else begin
      after_cr = 1'b0;
      push_cell(b, 1'b1, 1'b0, 1'b1);
      bump_column(1);
    end
  endfunction

  function automatic script_row_t row_p(logic [BYTE_W-1:0] b);
    script_row_t r;
    r.data_byte   = b;
    r.end_of_file = 1'b0;
    r.typed       = 1'b0;
    r.fixed_cell  = '0;
    return r;
  endfunction

  // Row whose single cell is known up front; attribute is the reset value.
  function automatic script_row_t row_x(logic [BYTE_W-1:0] b, logic eof,
                                        logic [BYTE_W-1:0] ch, logic is_text, logic lend);
    script_row_t r;
    r.data_byte   = b;
    r.end_of_file = eof;
    r.typed       = 1'b1;
    r.fixed_cell  = '{ch, CELL_ATTR_RST, is_text, lend, 1'b1};
    return r;
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 61 : (mode == IDLE_BOTH) ? 15 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 15 : 0;
  endfunction

  // Present one byte and hold it until the transfer; valid stays high on return
  // so back-to-back items keep it up. Typed rows replace the model's single cell.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eof,
                           input bit typed = 1'b0, input cell_t fixed = '0);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    predict_cells(b, eof);
    if (typed) begin
      pending_cells[pending_cells.size() - 1] = fixed;
    end
  endtask

  // Drop valid and hold until every predicted cell has arrived, then let the
  // block go quiet. Bounded so a lost cell shows up as a leftover, not a hang.
  task automatic wait_for_cells(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_cells.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do begin
      @(posedge clk);
    end while (cfg_ch.ready !== 1'b1);
    if (idx == REG_TAB_SIZE) begin
      tab_reg = value[TAB_SIZE_W-1:0];
    end else if (idx == REG_CELL_ATTR) begin
      attr_reg = value;
    end
  endtask

  // Reprogram both registers with the block idle; optionally hit an unmapped index.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] tab_val,
                          input logic [CFG_DATA_W-1:0] attr_val, input bit poke_unused);
    wait_for_cells(QUIET_CYCLES);
    cfg_write(REG_TAB_SIZE, tab_val);
    cfg_write(REG_CELL_ATTR, attr_val);
    if (poke_unused) begin
      cfg_write(CFG_INDEX_W'($urandom_range(2, (1 << CFG_INDEX_W) - 1)),
                CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random text: mostly printable runs with tabs and line ends, CR-LF pairs,
  // the occasional end of file and arbitrary bytes as noise.
  task automatic send_text(input int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_item(BYTE_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end else if (pick < 52) begin
        send_item(CH_TAB, 1'b0);
      end else if (pick < 60) begin
        send_item(CH_CR, 1'b0);
      end else if (pick < 68) begin
        send_item(CH_LF, 1'b0);
      end else if (pick < 76) begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end else if (pick < 80) begin
        send_item(BYTE_W'($urandom), 1'b1);
      end else begin
        send_item(BYTE_W'($urandom), 1'b0);
      end
    end
  endtask

  // Result side: check each transfer against the oldest prediction, then pick
  // this cycle's ready.
  always @(posedge clk) begin
    cell_t got;
    cell_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.char_code, out_ch.attribute, out_ch.is_cell, out_ch.line_end,
              out_ch.last_of_run};
      if (pending_cells.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected cell: ch=%02h attr=%02h cell=%0b end=%0b last=%0b",
                   got.char_code, got.attribute, got.is_cell, got.line_end,
                   got.last_of_run);
        end
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("cell mismatch: exp ch=%02h attr=%02h cell=%0b end=%0b last=%0b",
                     want.char_code, want.attribute, want.is_cell, want.line_end,
                     want.last_of_run);
            $display("               got ch=%02h attr=%02h cell=%0b end=%0b last=%0b",
                     got.char_code, got.attribute, got.is_cell, got.line_end,
                     got.last_of_run);
          end
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    logic [CFG_DATA_W-1:0] sat_tabs [4];

    // Drive every input to a known value and hold reset.
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.end_of_file  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    fail_count         = 0;
    tab_reg            = TAB_SIZE_RST;
    attr_reg           = CELL_ATTR_RST;
    line_col           = '0;
    after_cr           = 1'b0;
    set_idle(IDLE_NONE);

    // Directed script at reset settings (tab size 4, attribute 36).
    script_rows = '{
      row_x(8'h41, 1'b0, 8'h41, 1'b1, 1'b0),      // first byte after reset
      row_p(CH_TAB),                              // partial tab from column 1
      row_p(CH_TAB),                              // full tab from a stop
      row_x(CH_CR, 1'b0, CH_LF, 1'b1, 1'b1),
      row_p(CH_LF),                               // LF of a CR-LF pair: no cell
      row_x(CH_LF, 1'b0, CH_LF, 1'b1, 1'b1),      // lone LF
      row_x(8'h00, 1'b0, 8'h00, 1'b1, 1'b0),      // lowest byte
      row_x(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0),      // highest byte
      row_x(CH_CR, 1'b0, CH_LF, 1'b1, 1'b1),
      row_p(CH_TAB),                              // tab clears the CR flag
      row_x(CH_LF, 1'b0, CH_LF, 1'b1, 1'b1),      // so this LF is lone
      row_x(CH_CR, 1'b0, CH_LF, 1'b1, 1'b1),
      row_x(8'h00, 1'b1, CH_NUL, 1'b0, 1'b1),     // end of file after CR
      row_x(CH_LF, 1'b0, CH_LF, 1'b1, 1'b1),      // end of file cleared the flag
      row_x(8'hFF, 1'b1, CH_NUL, 1'b0, 1'b1),     // data ignored on end of file
      row_x(CH_CR, 1'b1, CH_NUL, 1'b0, 1'b1),
      row_x(CH_LF, 1'b1, CH_NUL, 1'b0, 1'b1),     // back-to-back close markers
      row_p(8'h7A),
      row_p(CH_TAB),
      row_p(8'h7F),
      row_p(CH_TAB),
      row_x(CH_TAB, 1'b1, CH_NUL, 1'b0, 1'b1)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      send_item(script_rows[i].data_byte, script_rows[i].end_of_file,
                script_rows[i].typed, script_rows[i].fixed_cell);
    end

    // Smallest tab stop, attribute zero, no idling.
    set_regs(8'd1, 8'h00, 1'b0);
    send_text(40);

    // Largest tab stop, all-ones attribute, idle sender; hold mid-phase until
    // the output side has drained completely.
    set_regs(8'd16, 8'hFF, 1'b0);
    set_idle(IDLE_SENDER);
    send_text(20);
    wait_for_cells(0);
    send_text(20);

    // Tab size zero acts as one; stalling receiver; also hit an unmapped index.
    set_regs(8'd0, 8'h5A, 1'b1);
    set_idle(IDLE_RECEIVER);
    send_text(40);

    // Upper data bits are dropped: 0xF1 leaves 17, which clamps to MAX_TAB.
    set_regs(8'hF1, 8'hA5, 1'b0);
    set_idle(IDLE_BOTH);
    send_text(40);

    // Random settings across all idle modes.
    for (int k = 0; k < 4; k++) begin
      set_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
      set_idle(idle_mode_t'(k));
      send_text(15);
    end

    // Move off a tab stop, then check tab fill at several stop sizes
    // (200 keeps 8 after masking).
    set_regs(8'd16, 8'h3C, 1'b0);
    set_idle(IDLE_NONE);
    for (int unsigned i = 0; i < LEAD_BYTES; i++) begin
      send_item(BYTE_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
    end
    send_item(CH_TAB, 1'b0);
    sat_tabs = '{8'd5, 8'd7, 8'd1, 8'd200};
    foreach (sat_tabs[i]) begin
      set_regs(sat_tabs[i], CFG_DATA_W'($urandom), 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(8'h2E, 1'b0);
    end
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h00, 1'b1);

    // Drain, settle, and count anything never delivered.
    wait_for_cells(END_SETTLE);
    fail_count += pending_cells.size();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tlnu_pkg.sv
rtl/tlnu_if.sv
rtl/tlnu_rem.sv
rtl/tab_expanding_line_normalizer_unit.sv
tb/tb.sv
